/* hw/rtl/lms_pkg.sv */
package lms_pkg;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    CFG_MIN_VALUE    = 2'd0,
    CFG_MAX_VALUE    = 2'd1,
    CFG_MARK_ENABLE  = 2'd2,
    CFG_RESERVED_FR  = 2'd3
  } cfg_idx_t;

  localparam logic [31:0] FULL32 = 32'hFFFF_FFFF;
  localparam logic [31:0] HALF32 = 32'h8000_0000;
  localparam logic [63:0] RST_MIN_VALUE = 64'd0;
  localparam logic [63:0] RST_MAX_VALUE = 64'd1;
  localparam logic [15:0] RST_RESERVED_FR = 16'd3277;

  // Per-transaction flags that travel beside the data path.
  typedef struct packed {
    logic        ends_equal;
    logic        invalid;
    logic        max_below_min;
    logic        shifted;
    logic [15:0] frac_r;
  } side_t;

  // Comparison results that travel through the divider.
  typedef struct packed {
    logic lx_zero;
    logic lm_zero;
    logic lx_above;
    logic lx_equal;
  } dflag_t;

endpackage

/* hw/rtl/log_minmax_scaler_unit.sv */
// Logarithmic min-max scaler. Each signed 64-bit sample is placed between the configured
// minimum and maximum on a log2 scale and returned as an inverted 32-bit position; invalid
// samples (only when marking is enabled) give all ones. It takes one transaction per clock
// while the output is not stalled. Samples pass the sample and difference registers, the
// leading-one search and normalization, the squarings of the three parallel log2 lanes (one
// 32x32 squaring per lane and fraction bit), a pipelined restoring divider, and the scaling
// and output registers. A stalled output freezes the whole pipeline, so nothing is lost.
module log_minmax_scaler_unit #(
  parameter int LOG_FRACTION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] sample_value
  input  logic        in_tuser,   // [0] sample_invalid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] scaled_position
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int FB   = LOG_FRACTION_BITS;
  localparam int LW   = 7 + FB;
  localparam int NDIV = 32;
  localparam int SQ0  = 5;
  localparam int DF   = SQ0 + FB + 1;
  localparam int MU   = DF + NDIV + 1;
  localparam int OUTS = MU + 1;
  localparam int NSTG = OUTS + 1;

  logic [63:0] min_r, max_r;
  logic        mark_r;
  logic [15:0] rfrac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= lms_pkg::RST_MIN_VALUE;
      max_r   <= lms_pkg::RST_MAX_VALUE;
      mark_r  <= 1'b0;
      rfrac_r <= lms_pkg::RST_RESERVED_FR;
    end else if (cfg_we) begin
      case (cfg_index)
        lms_pkg::CFG_MIN_VALUE:   min_r   <= cfg_wdata;
        lms_pkg::CFG_MAX_VALUE:   max_r   <= cfg_wdata;
        lms_pkg::CFG_MARK_ENABLE: mark_r  <= cfg_wdata[0];
        lms_pkg::CFG_RESERVED_FR: rfrac_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic            vld_r  [NSTG];
  lms_pkg::side_t  side_r [NSTG];

  assign en         = !vld_r[OUTS] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[OUTS];

  lms_pkg::side_t side_nxt;
  always_comb begin
    side_nxt.ends_equal    = (min_r == max_r);
    side_nxt.invalid       = in_tuser && mark_r;
    side_nxt.max_below_min = ($signed(max_r) < $signed(min_r));
    side_nxt.shifted       = ($signed(min_r) <= 64'sd0);
    side_nxt.frac_r        = mark_r ? rfrac_r : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int s = 1; s < NSTG; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < NSTG; s++) side_r[s] <= side_r[s-1];
    end
  end

  // Stage 0 holds the sample; stage 1 forms x'-1, min'-1 and max'-1 on three lanes.
  logic [63:0] x_r;
  logic [63:0] d_r [3];
  logic [63:0] d_nxt [3];
  logic [63:0] xc;

  always_comb begin
    xc = ($signed(x_r) < $signed(min_r)) ? min_r : x_r;
    if (side_r[0].shifted) begin
      d_nxt[0] = xc - min_r;
      d_nxt[1] = 64'd0;
      d_nxt[2] = max_r - min_r;
    end else begin
      d_nxt[0] = xc - 64'd1;
      d_nxt[1] = min_r - 64'd1;
      d_nxt[2] = max_r - 64'd1;
    end
  end

  // Log2 lanes: increment, byte search, bit search, normalize, then squarings.
  logic [63:0] v2_r [3], v3_r [3], v4_r [3];
  logic        f2_r [3], f3_r [3], f4_r [3];
  logic [2:0]  gi_r [3];
  logic [5:0]  e4_r [3];
  logic [2:0]  gi_nxt [3];
  logic [5:0]  e_nxt [3];
  logic [31:0] m_nxt [3];

  logic [31:0]   mq_r [FB+1][3];
  logic [FB-1:0] fq_r [FB+1][3];
  logic [5:0]    eq_r [FB+1][3];
  logic          fl_r [FB+1][3];
  logic [63:0]   sqp  [FB][3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [7:0]  byt;
      logic [95:0] wide;
      gi_nxt[l] = 3'd0;
      for (int g = 0; g < 8; g++)
        if (|v2_r[l][8*g +: 8]) gi_nxt[l] = 3'(g);
      byt = v3_r[l][8*gi_r[l] +: 8];
      e_nxt[l] = {gi_r[l], 3'd0};
      for (int b = 0; b < 8; b++)
        if (byt[b]) e_nxt[l] = {gi_r[l], 3'(b)};
      wide = {v4_r[l], 32'd0} >> (7'(e4_r[l]) + 7'd1);
      m_nxt[l] = wide[31:0];
    end
  end

  always_comb begin
    for (int k = 0; k < FB; k++)
      for (int l = 0; l < 3; l++)
        sqp[k][l] = mq_r[k][l] * mq_r[k][l];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= in_tdata;
      for (int l = 0; l < 3; l++) begin
        d_r[l]  <= d_nxt[l];
        v2_r[l] <= d_r[l] + 64'd1;
        f2_r[l] <= &d_r[l];
        v3_r[l] <= v2_r[l];
        f3_r[l] <= f2_r[l];
        gi_r[l] <= gi_nxt[l];
        v4_r[l] <= v3_r[l];
        f4_r[l] <= f3_r[l];
        e4_r[l] <= e_nxt[l];
        mq_r[0][l] <= m_nxt[l];
        fq_r[0][l] <= '0;
        eq_r[0][l] <= e4_r[l];
        fl_r[0][l] <= f4_r[l];
        for (int k = 0; k < FB; k++) begin
          mq_r[k+1][l] <= sqp[k][l][63] ? sqp[k][l][63:32] : sqp[k][l][62:31];
          fq_r[k+1][l] <= {fq_r[k][l][FB-2:0], sqp[k][l][63]};
          eq_r[k+1][l] <= eq_r[k][l];
          fl_r[k+1][l] <= fl_r[k][l];
        end
      end
    end
  end

  // Differences of the logs and the cases the divider cannot settle.
  logic [LW-1:0] lg [3];
  logic [LW-1:0] lx_nxt, lm_nxt;
  lms_pkg::dflag_t df_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++)
      lg[l] = fl_r[FB][l] ? (LW'(64) << FB) : {1'b0, eq_r[FB][l], fq_r[FB][l]};
    lx_nxt = lg[0] - lg[1];
    lm_nxt = lg[2] - lg[1];
    df_nxt.lx_zero  = (lx_nxt == '0);
    df_nxt.lm_zero  = (lm_nxt == '0);
    df_nxt.lx_above = (lx_nxt > lm_nxt);
    df_nxt.lx_equal = (lx_nxt == lm_nxt);
  end

  logic [LW-1:0]   rem_r [NDIV+1];
  logic [LW-1:0]   lm_r  [NDIV+1];
  logic [31:0]     t_r   [NDIV+1];
  lms_pkg::dflag_t df_r  [NDIV+1];
  logic [LW:0]     rsh   [NDIV];

  always_comb begin
    for (int k = 0; k < NDIV; k++) rsh[k] = {rem_r[k], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= lx_nxt;
      lm_r[0]  <= lm_nxt;
      t_r[0]   <= '0;
      df_r[0]  <= df_nxt;
      for (int k = 0; k < NDIV; k++) begin
        if (rsh[k] >= {1'b0, lm_r[k]}) begin
          rem_r[k+1] <= LW'(rsh[k] - {1'b0, lm_r[k]});
          t_r[k+1]   <= {t_r[k][30:0], 1'b1};
        end else begin
          rem_r[k+1] <= rsh[k][LW-1:0];
          t_r[k+1]   <= {t_r[k][30:0], 1'b0};
        end
        lm_r[k+1] <= lm_r[k];
        df_r[k+1] <= df_r[k];
      end
    end
  end

  // (2^32-1)*t/2^32 reduces to t-1 for nonzero t, and to all ones for t = 2^32.
  logic [31:0] u;
  logic [48:0] term_prod;
  logic [47:0] off_prod;
  logic [31:0] term_r, off_r;
  lms_pkg::dflag_t dfm_r;

  always_comb begin
    if (df_r[NDIV].lx_equal) u = lms_pkg::FULL32;
    else if (t_r[NDIV] == '0) u = '0;
    else u = t_r[NDIV] - 32'd1;
    term_prod = u * (17'h10000 - {1'b0, side_r[MU-1].frac_r});
    off_prod  = lms_pkg::FULL32 * side_r[MU-1].frac_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_prod[47:16];
      off_r  <= off_prod[47:16];
      dfm_r  <= df_r[NDIV];
    end
  end

  logic [31:0] term_sel, res_nxt, res_r;
  logic [32:0] pos;

  always_comb begin
    if (side_r[MU].max_below_min || dfm_r.lm_zero)
      term_sel = dfm_r.lx_zero ? 32'd0 : lms_pkg::FULL32;
    else if (dfm_r.lx_above)
      term_sel = lms_pkg::FULL32;
    else
      term_sel = term_r;
    pos = {1'b0, term_sel} + {1'b0, off_r};
    if (side_r[MU].ends_equal)
      res_nxt = side_r[MU].invalid ? lms_pkg::FULL32 : lms_pkg::HALF32;
    else if (side_r[MU].invalid)
      res_nxt = lms_pkg::FULL32;
    else
      res_nxt = pos[32] ? 32'd0 : ~pos[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign out_tdata = res_r;

endmodule

/* hw/rtl/lms_checker.sv */
module lms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A result that waits keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("held result changed");

  // The input side is stalled exactly when a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == !(out_tvalid && !out_tready))
    else $error("input ready does not follow the output stall");

  // Nothing comes out in the cycle after reset.
  assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result shown right after reset");

endmodule

bind log_minmax_scaler_unit lms_checker u_lms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/tb_log_minmax_scaler_unit.sv */
module tb_log_minmax_scaler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 32;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic signed [63:0] value;
    logic               invalid;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  lms_pkg::cfg_idx_t cfg_index = lms_pkg::CFG_MIN_VALUE;
  logic [63:0] cfg_wdata = '0;

  log_minmax_scaler_unit #(.LOG_FRACTION_BITS(FRAC_BITS)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scale settings as the block should currently hold them.
  logic signed [63:0] scale_min = lms_pkg::RST_MIN_VALUE;
  logic signed [63:0] scale_max = lms_pkg::RST_MAX_VALUE;
  logic               mark_en = 1'b0;
  logic [15:0]        mark_frac = lms_pkg::RST_RESERVED_FR;

  sample_t     pending_samples[$];
  logic [31:0] expected_positions[$];
  int          errors = 0;
  int          sent = 0;
  int          received = 0;
  int          invalid_sent = 0;
  bit          no_gaps = 1'b0;

  // log2(d + 1) in Q7.32, mantissa squared once per fraction bit.
  function automatic logic [63:0] log2_plus_one(logic [63:0] d);
    logic [63:0] v, m, p, frac;
    int e;
    if (d == '1) return 64'd64 << FRAC_BITS;
    v = d + 64'd1;
    e = 63;
    frac = '0;
    while (v[e] == 1'b0) e--;
    m = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
    for (int i = 0; i < FRAC_BITS; i++) begin
      p = m * m;
      if (p[63]) begin
        frac = (frac << 1) | 64'd1;
        m = p >> 32;
      end else begin
        frac = frac << 1;
        m = p >> 31;
      end
    end
    return (64'(e) << FRAC_BITS) | frac;
  endfunction

  function automatic logic [31:0] scale_position(sample_t s);
    logic signed [63:0] x;
    logic        bad, shifted;
    logic [63:0] r, offset, term, pos, lmin, lx, lm, t, rem, u;
    bad = s.invalid && mark_en;
    shifted = (scale_min <= 0);
    r = mark_en ? 64'(mark_frac) : 64'd0;
    if (scale_min == scale_max) return bad ? lms_pkg::FULL32 : lms_pkg::HALF32;
    if (bad) return lms_pkg::FULL32;
    offset = (64'(lms_pkg::FULL32) * r) >> 16;
    lmin = log2_plus_one(shifted ? 64'd0 : scale_min - 64'd1);
    x = (s.value < scale_min) ? scale_min : s.value;
    lx = log2_plus_one(shifted ? x - scale_min : x - 64'd1) - lmin;
    if (scale_max < scale_min) begin
      term = (lx == 0) ? 64'd0 : 64'(lms_pkg::FULL32);
    end else begin
      lm = log2_plus_one(shifted ? scale_max - scale_min : scale_max - 64'd1) - lmin;
      if (lm == 0) begin
        term = (lx == 0) ? 64'd0 : 64'(lms_pkg::FULL32);
      end else if (lx > lm) begin
        term = 64'(lms_pkg::FULL32);
      end else begin
        t = '0;
        rem = lx;
        if (lx == lm) begin
          t = 64'd1 << 32;
        end else begin
          for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            t = t << 1;
            if (rem >= lm) begin
              rem = rem - lm;
              t = t | 64'd1;
            end
          end
        end
        u = (64'(lms_pkg::FULL32) * t) >> 32;
        term = (u * (64'd65536 - r)) >> 16;
      end
    end
    pos = term + offset;
    if (pos > 64'(lms_pkg::FULL32)) pos = 64'(lms_pkg::FULL32);
    return ~pos[31:0];
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, received);
    errors++;
  endtask

  // Sender: presents pending samples, keeping one steady while the block stalls.
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_positions.push_back(scale_position(pending_samples[0]));
        invalid_sent += pending_samples[0].invalid;
        void'(pending_samples.pop_front());
        sent++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_samples[0].value;
          in_tuser <= pending_samples[0].invalid;
          in_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, checks each transaction against the oldest expectation.
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_positions.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 'x);
        end else begin
          if (out_tdata !== expected_positions[0])
            report_mismatch("scaled_position", out_tdata, expected_positions[0]);
          void'(expected_positions.pop_front());
        end
        received++;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[log_minmax_scaler_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(lms_pkg::cfg_idx_t idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      lms_pkg::CFG_MIN_VALUE:   scale_min = data;
      lms_pkg::CFG_MAX_VALUE:   scale_max = data;
      lms_pkg::CFG_MARK_ENABLE: mark_en = data[0];
      lms_pkg::CFG_RESERVED_FR: mark_frac = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_scale(logic signed [63:0] lo, logic signed [63:0] hi, logic en,
                           logic [15:0] frac);
    write_reg(lms_pkg::CFG_MIN_VALUE, lo);
    write_reg(lms_pkg::CFG_MAX_VALUE, hi);
    write_reg(lms_pkg::CFG_MARK_ENABLE, {63'd0, en});
    write_reg(lms_pkg::CFG_RESERVED_FR, {48'd0, frac});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_sample(logic signed [63:0] v, logic bad);
    sample_t s;
    s.value = v;
    s.invalid = bad;
    pending_samples.push_back(s);
  endtask

  // Mostly values spread over every magnitude, plus hits on and next to the ends.
  task automatic add_random(int n);
    logic signed [63:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: v = scale_min + $signed(64'($urandom_range(0, 2))) - 64'sd1;
        1: v = scale_max + $signed(64'($urandom_range(0, 2))) - 64'sd1;
        2: v = {$urandom, $urandom};
        default: begin
          v = {$urandom, $urandom} >> $urandom_range(1, 63);
          if ($urandom_range(0, 3) == 0) v = -v;
        end
      endcase
      add_sample(v, $urandom_range(0, 4) == 0);
    end
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && expected_positions.size() == 0);
    @(posedge clk);
  endtask

  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset scale: min 0, max 1, marking off so the invalid flag is ignored.
    add_sample(0, 1'b1);
    add_sample(1, 1'b0);
    add_sample(S64_MIN, 1'b0);
    add_sample(S64_MAX, 1'b1);
    drain();

    set_scale(1, 1000, 1'b1, 16'd3277);
    add_sample(1, 1'b0);
    add_sample(1000, 1'b0);
    add_sample(999, 1'b0);
    add_sample(-5, 1'b0);
    add_sample(1001, 1'b0);
    add_sample(32, 1'b1);
    drain();

    set_scale(S64_MIN, S64_MAX, 1'b1, 16'hFFFF);
    add_sample(S64_MIN, 1'b0);
    add_sample(S64_MAX, 1'b0);
    add_sample(0, 1'b0);
    add_sample(-1, 1'b1);
    drain();

    // Equal ends, then inverted ends, then ends too close to resolve.
    set_scale(42, 42, 1'b1, 16'd0);
    add_sample(42, 1'b0);
    add_sample(7, 1'b1);
    add_sample(S64_MAX, 1'b0);
    drain();

    set_scale(S64_MAX, -3, 1'b0, 16'd0);
    add_sample(S64_MAX, 1'b0);
    add_sample(S64_MIN, 1'b1);
    add_sample(S64_MAX - 1, 1'b0);
    drain();

    set_scale(S64_MAX - 1, S64_MAX, 1'b0, 16'd100);
    add_sample(S64_MAX - 1, 1'b0);
    add_sample(S64_MAX, 1'b0);
    drain();

    no_gaps = 1'b1;
    set_scale(-100, 100000, 1'b1, 16'd3277);
    add_random(60);
    drain();
    no_gaps = 1'b0;

    set_scale(10, 64'sd1 << 40, 1'b1, 16'd0);
    add_random(60);
    drain();
    set_scale(S64_MIN, S64_MAX, 1'b0, 16'hFFFF);
    add_random(60);
    drain();
    set_scale(1, S64_MAX, 1'b1, 16'hFFFF);
    add_random(60);
    drain();
    set_scale(5, 6, 1'b1, 16'd1);
    add_random(40);
    drain();
    for (int k = 0; k < 4; k++) begin
      set_scale(-$signed(64'($urandom_range(0, 1000))), {1'b0, $urandom, 31'd0} >> k * 12,
                1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      add_random(37);
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Sent %0d samples (%0d flagged invalid) and checked %0d positions", sent,
             invalid_sent, received);
    $display("over equal, inverted, close and full-range scales, marking on and off.");
    if (errors == 0 && expected_positions.size() == 0) begin
      $display("[log_minmax_scaler_unit] OK");
    end else begin
      $display("[log_minmax_scaler_unit] ERROR");
    end
    $finish;
  end

endmodule
